FILE: rtl/ptwp_pkg.sv
// Shared types, constants and arctangent table for the path turn waypoint picker.
package ptwp_pkg;

    localparam int COORD_BITS   = 16;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int SCALE_SHIFT  = 24;
    localparam int CW           = COORD_BITS + SCALE_SHIFT + 4;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_BITS    = 4;
    localparam int ATAN_BITS    = 18;
    localparam int ZW           = 20;
    localparam int TW           = 22;
    localparam int ANGLE_FRAC   = 8;
    localparam int HEAD_BITS    = 13;
    localparam int HEADING_FULL = 5760;
    localparam int COUNT_BITS   = 16;
    localparam int THR_BITS     = 13;

    localparam logic [STEP_BITS-1:0]  STEP_LAST  = STEP_BITS'(CORDIC_STEPS - 1);
    localparam logic [THR_BITS-1:0]   THR_RESET  = THR_BITS'(80);
    localparam logic [TW-1:0]         BASE_HALF  = TW'((HEADING_FULL / 2) << ANGLE_FRAC);
    localparam logic [TW-1:0]         FULL_TURN  = TW'(HEADING_FULL << ANGLE_FRAC);
    localparam logic [TW-1:0]         ROUND_HALF = TW'(1 << (ANGLE_FRAC - 1));
    localparam logic [HEAD_BITS:0]    HEAD_WRAP  = (HEAD_BITS + 1)'(HEADING_FULL);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    // atan(2^-i) in 1/4096 degree
    localparam logic [ATAN_BITS-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        18'd184320, 18'd108810, 18'd57492, 18'd29184,
        18'd14649,  18'd7331,   18'd3667,  18'd1833,
        18'd917,    18'd458,    18'd229,   18'd115,
        18'd57,     18'd29,     18'd14,    18'd7
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         end_of_path;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] waypoint_x;
        logic signed [COORD_BITS-1:0] waypoint_y;
        logic                         is_final;
        logic [COUNT_BITS-1:0]        turns_seen;
    } t_out_item;

    typedef struct packed {
        logic                 load;
        logic                 rot;
        logic [STEP_BITS-1:0] step;
        logic                 head;
        logic                 cmp;
        logic                 emit_turn;
        logic                 emit_final;
        logic                 store;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic hit;
        logic last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/path_turn_waypoint_picker.sv
// Top level of the path turn waypoint picker: controller, datapath and ports.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------
//  input   | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  output  | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//  config  | i_cfg_we                   | i_cfg_wdata (turn threshold)
//
// A point after the first of a path goes through load, 16 CORDIC vectoring steps on one shared
// add/shift unit, heading, turn test, a turn item when one is found, and store or final item.
// The first point of a path goes through load and store or final item. One item is in work at a time.
// Reset is synchronous and clears path state; the threshold resets to 80.
// A stalled output holds the emitting step until the output register frees.
module path_turn_waypoint_picker import ptwp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    ptwp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ptwp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/ptwp_dp.sv
// Datapath: path state, CORDIC heading unit, turn test and output register.
module ptwp_dp import ptwp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  t_in_item            i_in_item,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item
);

    logic signed [CW-1:0]         r_x, r_y;
    logic signed [ZW-1:0]         r_z;
    logic                         r_neg, r_zero;
    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y;
    logic                         r_last;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic                         r_have_prev;
    logic [HEAD_BITS-1:0]         r_ref, r_heading;
    logic [COUNT_BITS-1:0]        r_count;
    logic [THR_BITS-1:0]          r_thr;
    logic                         r_out_valid;
    t_out_item                    r_out;

    logic signed [DIFF_BITS-1:0]  ext_x, ext_y, ext_px, ext_py, dx, dy;
    logic signed [CW-1:0]         vx, vy, x0, y0;
    logic signed [CW-1:0]         xs, ys;
    logic signed [ZW-1:0]         atan_s;
    logic signed [TW-1:0]         z_ext, base_s, total, wrapped, rounded;
    logic [HEAD_BITS:0]           h_wide;
    logic [HEAD_BITS-1:0]         heading, diff;
    logic                         hit, out_free;

    // segment setup
    always_comb begin
        ext_x  = {i_in_item.point_x[COORD_BITS-1], i_in_item.point_x};
        ext_y  = {i_in_item.point_y[COORD_BITS-1], i_in_item.point_y};
        ext_px = {r_prev_x[COORD_BITS-1], r_prev_x};
        ext_py = {r_prev_y[COORD_BITS-1], r_prev_y};
        dx     = ext_x - ext_px;
        dy     = ext_y - ext_py;
        vx     = CW'(dx);
        vy     = -CW'(dy);
        if (dx[DIFF_BITS-1]) begin
            vx = -vx;
            vy = -vy;
        end
        x0 = vx <<< SCALE_SHIFT;
        y0 = vy <<< SCALE_SHIFT;
    end

    // CORDIC step operands
    always_comb begin
        xs     = r_x >>> i_cmd.step;
        ys     = r_y >>> i_cmd.step;
        atan_s = signed'(ZW'(ATAN_TABLE[i_cmd.step]));
    end

    // angle to heading
    always_comb begin
        z_ext   = TW'(r_z);
        base_s  = r_neg ? signed'(BASE_HALF) : '0;
        total   = base_s + z_ext;
        wrapped = total[TW-1] ? total + signed'(FULL_TURN) : total;
        rounded = wrapped + signed'(ROUND_HALF);
        h_wide  = rounded[ANGLE_FRAC +: HEAD_BITS+1];
        if (h_wide >= HEAD_WRAP) begin
            h_wide = h_wide - HEAD_WRAP;
        end
        heading = r_zero ? '0 : h_wide[HEAD_BITS-1:0];
    end

    always_comb begin
        diff     = (r_heading > r_ref) ? r_heading - r_ref : r_ref - r_heading;
        hit      = diff > r_thr;
        out_free = !r_out_valid || !i_out_stall;
    end

    assign o_status = '{have_prev: r_have_prev, hit: hit, last: r_last, out_free: out_free};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x <= i_in_item.point_x;
            r_cur_y <= i_in_item.point_y;
            r_last  <= i_in_item.end_of_path;
            r_x     <= x0;
            r_y     <= y0;
            r_z     <= '0;
            r_neg   <= dx[DIFF_BITS-1];
            r_zero  <= (dx == '0) && (dy == '0);
        end
        if (i_cmd.rot) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_s;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_s;
            end
        end
        if (i_cmd.head) begin
            r_heading <= heading;
        end
        if (i_cmd.emit_turn) begin
            r_out <= '{waypoint_x: r_prev_x, waypoint_y: r_prev_y,
                       is_final: 1'b0, turns_seen: r_count};
        end
        if (i_cmd.emit_final) begin
            r_out <= '{waypoint_x: r_cur_x, waypoint_y: r_cur_y,
                       is_final: 1'b1, turns_seen: r_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_ref       <= '0;
            r_count     <= '0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.cmp) begin
                r_ref <= r_heading;
                if (hit && r_count != COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.store) begin
                r_prev_x    <= r_cur_x;
                r_prev_y    <= r_cur_y;
                r_have_prev <= 1'b1;
            end
            if (i_cmd.emit_final) begin
                r_prev_x    <= '0;
                r_prev_y    <= '0;
                r_have_prev <= 1'b0;
                r_ref       <= '0;
                r_count     <= '0;
            end
            if (i_cmd.emit_turn || i_cmd.emit_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_turn || i_cmd.emit_final) |-> (!r_out_valid || !i_out_stall))
        else $error("item emitted over a pending result");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_final |=> (!r_have_prev && r_count == '0 && r_ref == '0))
        else $error("path state not cleared after final item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled output item changed");

endmodule

FILE: rtl/ptwp_ctrl.sv
// Controller: sequences load, CORDIC steps, turn test and result emission.
module ptwp_ctrl import ptwp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_TURN = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = i_status.have_prev ? S_ROT : S_LAST;
                end
            end
            S_ROT: begin
                o_cmd.rot  = 1'b1;
                o_cmd.step = r_step;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_status.hit ? S_TURN : S_LAST;
            end
            S_TURN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_turn = 1'b1;
                    n_state         = S_LAST;
                end
            end
            S_LAST: begin
                if (i_status.last) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_final = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_rot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && r_step == STEP_LAST) |=> (r_state == S_HEAD))
        else $error("CORDIC did not finish after last step");

    a_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && !i_status.hit) |=> (r_state == S_LAST))
        else $error("turn emitted without heading change");

    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_status.have_prev) |=> (r_state == S_ROT && r_step == '0))
        else $error("CORDIC not started from step zero");

endmodule

FILE: tb/path_turn_waypoint_picker_tb.sv
`timescale 1ns / 100ps
// Testbench for the path turn waypoint picker: queued path points, heading predictor, item checks.
module path_turn_waypoint_picker_tb;
    import ptwp_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 50;
    localparam int THR_AT_RESET  = 80;
    localparam int HALF_TURN     = 180 * 16 * 256;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    t_in_item            in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_item;
    logic                cfg_we    = 1'b0;
    logic [THR_BITS-1:0] cfg_wdata = '0;

    // atan(2^-i) in 1/4096 degree
    longint dir_atan [16] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic [THR_BITS-1:0]          thr_model  = THR_BITS'(THR_AT_RESET);
    logic signed [COORD_BITS-1:0] last_x     = '0;
    logic signed [COORD_BITS-1:0] last_y     = '0;
    logic                         path_open  = 1'b0;
    logic [HEAD_BITS-1:0]         ref_dir    = '0;
    logic [COUNT_BITS-1:0]        turn_tally = '0;

    t_in_item  point_queue [$];
    t_out_item waypoint_expect [$];

    bit          in_taken      = 1'b0;
    bit          long_hold_req = 1'b0;
    int          burst_left    = 1;
    int          gap_left      = 0;
    int          hold_left     = 0;
    int          mode_left     = 0;
    t_stall_mode stall_mode    = STALL_NONE;
    int          idle_cycles   = 0;
    int          mismatch_count = 0;

    path_turn_waypoint_picker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
        mismatch_count++;
    endtask

    // heading of a segment in 1/16 degree, 16-step CORDIC vectoring
    function automatic int segment_heading(longint dx, longint dy);
        longint x, y, z, base, total, xs, ys;
        int i, h;
        if (dx == 0 && dy == 0) begin
            return 0;
        end
        x = dx;
        y = -dy;
        z = 0;
        base = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            base = HALF_TURN;
        end
        x = x <<< 24;
        y = y <<< 24;
        for (i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += dir_atan[i];
            end else begin
                x -= ys;
                y += xs;
                z -= dir_atan[i];
            end
        end
        total = base + z;
        if (total < 0) begin
            total += longint'(HEADING_FULL) * 256;
        end
        h = int'((total + 128) >>> 8);
        if (h >= HEADING_FULL) begin
            h -= HEADING_FULL;
        end
        return h;
    endfunction

    task automatic predict_point(t_in_item it);
        int h, d;
        t_out_item r;
        if (path_open) begin
            h = segment_heading(longint'($signed(it.point_x)) - longint'($signed(last_x)),
                                longint'($signed(it.point_y)) - longint'($signed(last_y)));
            d = (h > int'(ref_dir)) ? h - int'(ref_dir) : int'(ref_dir) - h;
            if (d > int'(thr_model)) begin
                if (turn_tally != COUNT_MAX) begin
                    turn_tally++;
                end
                r.waypoint_x = last_x;
                r.waypoint_y = last_y;
                r.is_final   = 1'b0;
                r.turns_seen = turn_tally;
                waypoint_expect = {waypoint_expect, r};
            end
            ref_dir = HEAD_BITS'(h);
        end
        if (it.end_of_path) begin
            r.waypoint_x = it.point_x;
            r.waypoint_y = it.point_y;
            r.is_final   = 1'b1;
            r.turns_seen = turn_tally;
            waypoint_expect = {waypoint_expect, r};
            last_x     = '0;
            last_y     = '0;
            path_open  = 1'b0;
            ref_dir    = '0;
            turn_tally = '0;
        end else begin
            last_x    = it.point_x;
            last_y    = it.point_y;
            path_open = 1'b1;
        end
    endtask

    task automatic queue_point(int x, int y, bit last);
        t_in_item it;
        it.point_x     = COORD_BITS'(x);
        it.point_y     = COORD_BITS'(y);
        it.end_of_path = last;
        point_queue = {point_queue, it};
    endtask

    task automatic wait_drained;
        while (point_queue.size() != 0 || in_valid || waypoint_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(int thr);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = THR_BITS'(thr);
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // sender: bursts of items with random gaps
    always @(negedge i_clk) begin : sender
        logic     nv;
        t_in_item nxt;
        if (!in_valid || in_taken) begin
            nv  = 1'b0;
            nxt = in_item;
            if (gap_left > 0) begin
                gap_left--;
            end else if (point_queue.size() != 0) begin
                nxt = point_queue.pop_front();
                nv  = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            in_valid <= nv;
            in_item  <= nxt;
        end
    end

    // receiver: stall pattern, plus one long hold-off on request
    always @(negedge i_clk) begin : receiver
        logic ns;
        if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            ns            = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(8, 150);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  ns = 1'b0;
                STALL_LIGHT: ns = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: ns = ($urandom_range(0, 3) != 0);
                default:     ns = mode_left[2];
            endcase
        end
        out_stall <= ns;
    end

    always @(posedge i_clk) begin : monitor
        bit        out_taken;
        t_out_item want;
        if (!i_rst_n) begin
            in_taken   = 1'b0;
            thr_model  = THR_BITS'(THR_AT_RESET);
            last_x     = '0;
            last_y     = '0;
            path_open  = 1'b0;
            ref_dir    = '0;
            turn_tally = '0;
        end else begin
            in_taken  = in_valid && !in_stall;
            out_taken = out_valid && !out_stall;
            if (out_taken) begin
                if (waypoint_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected item x=%0d y=%0d final=%0d turns=%0d",
                        out_item.waypoint_x, out_item.waypoint_y, out_item.is_final,
                        out_item.turns_seen));
                end else begin
                    want = waypoint_expect.pop_front();
                    if (out_item.waypoint_x !== want.waypoint_x) begin
                        report_mismatch($sformatf("waypoint_x got %0d want %0d",
                            out_item.waypoint_x, want.waypoint_x));
                    end
                    if (out_item.waypoint_y !== want.waypoint_y) begin
                        report_mismatch($sformatf("waypoint_y got %0d want %0d",
                            out_item.waypoint_y, want.waypoint_y));
                    end
                    if (out_item.is_final !== want.is_final) begin
                        report_mismatch($sformatf("is_final got %0d want %0d",
                            out_item.is_final, want.is_final));
                    end
                    if (out_item.turns_seen !== want.turns_seen) begin
                        report_mismatch($sformatf("turns_seen got %0d want %0d",
                            out_item.turns_seen, want.turns_seen));
                    end
                end
            end
            if (cfg_we) begin
                thr_model = cfg_wdata;
            end
            if (in_taken) begin
                predict_point(in_item);
            end
            if (in_taken || out_taken ||
                (point_queue.size() == 0 && !in_valid && waypoint_expect.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase, n, len, k, px, py, dx, dy, thr;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, threshold at its reset value
        queue_point(0, 0, 1'b1);                 // single-point path
        queue_point(-32768, -32768, 1'b0);       // full-range segments
        queue_point(32767, -32768, 1'b0);
        queue_point(32767, 32767, 1'b0);
        queue_point(-32768, 32767, 1'b0);
        queue_point(-32768, -32768, 1'b0);
        queue_point(-32768, -32768, 1'b0);       // zero-length segment
        queue_point(32767, 32767, 1'b1);         // turn and final together
        queue_point(0, 0, 1'b0);                 // just below 360 vs reference 0
        queue_point(100, 1, 1'b0);
        queue_point(200, 1, 1'b0);
        queue_point(300, 0, 1'b0);
        queue_point(400, 0, 1'b1);
        queue_point(10, 10, 1'b0);               // one segment per quadrant
        queue_point(20, 0, 1'b0);
        queue_point(10, -10, 1'b0);
        queue_point(0, 0, 1'b0);
        queue_point(10, 10, 1'b0);
        queue_point(10, 10, 1'b1);
        wait_drained();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       thr = 0;
                1:       thr = 8191;
                2:       thr = $urandom_range(40, 400);
                3:       thr = 5759;
                4:       thr = 1;
                5:       thr = $urandom_range(0, 5759);
                6:       thr = $urandom_range(0, 8191);
                default: thr = 2880;
            endcase
            write_threshold(thr);
            n = 0;
            while (n < 100) begin
                len = $urandom_range(1, 12);
                px  = int'($urandom_range(0, 65535)) - 32768;
                py  = int'($urandom_range(0, 65535)) - 32768;
                dx  = int'($urandom_range(0, 128)) - 64;
                dy  = int'($urandom_range(0, 128)) - 64;
                for (k = 0; k < len; k++) begin
                    if (k > 0) begin
                        case ($urandom_range(0, 5))
                            0: begin
                                px = int'($urandom_range(0, 65535)) - 32768;
                                py = int'($urandom_range(0, 65535)) - 32768;
                            end
                            1: begin
                                px += dx;
                                py += dy;
                            end
                            2: ;
                            default: begin
                                dx = int'($urandom_range(0, 128)) - 64;
                                dy = int'($urandom_range(0, 128)) - 64;
                                px += dx;
                                py += dy;
                            end
                        endcase
                    end
                    queue_point(px, py, (k == len - 1) || ($urandom_range(0, 19) == 0));
                    n++;
                end
            end
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ptwp_pkg.sv
rtl/ptwp_dp.sv
rtl/ptwp_ctrl.sv
rtl/path_turn_waypoint_picker.sv
tb/path_turn_waypoint_picker_tb.sv
